### rtl/hsv_to_rgb_converter_macros.svh
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define HSVRGB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence a fixed number of cycles after its cause.
`define HSVRGB_ASSERT_LATER(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int FIELD_BITS = 8;
   localparam int HUE_BITS = 9;
   localparam int REM_BITS = 6;
   localparam int SECTOR_DEG = 60;
   localparam logic [HUE_BITS-1:0] HUE_MAX = 9'd359;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int LATENCY = 6;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]   hue;
      logic [FIELD_BITS-1:0] saturation;
      logic [FIELD_BITS-1:0] brightness;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] red;
      logic [FIELD_BITS-1:0] green;
      logic [FIELD_BITS-1:0] blue;
   } rsp_word_type;

   typedef struct packed {
      logic                  grey;
      sector_type            sector;
      logic [REM_BITS-1:0]   rem;
      logic [FIELD_BITS-1:0] sat;
      logic [FIELD_BITS-1:0] val;
   } hsv_item_type;

   typedef struct packed {
      logic [QCW-1:0] count;
      logic           popping;
   } queue_level_type;

   function automatic sector_type hue_sector(input logic [HUE_BITS-1:0] h);
      sector_type sec;
      priority if (h >= 9'd300) sec = SECTOR_5;
      else if (h >= 9'd240) sec = SECTOR_4;
      else if (h >= 9'd180) sec = SECTOR_3;
      else if (h >= 9'd120) sec = SECTOR_2;
      else if (h >= 9'd60) sec = SECTOR_1;
      else sec = SECTOR_0;
      return sec;
   endfunction

   function automatic logic [HUE_BITS-1:0] sector_base(input sector_type sec);
      logic [HUE_BITS-1:0] base;
      unique case (sec)
         SECTOR_0: base = 9'd0;
         SECTOR_1: base = 9'd60;
         SECTOR_2: base = 9'd120;
         SECTOR_3: base = 9'd180;
         SECTOR_4: base = 9'd240;
         default:  base = 9'd300;
      endcase
      return base;
   endfunction

endpackage

### rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"

// HSV to RGB pixel converter. Takes one pixel per clock: a pixel is taken at
// a rising edge where start is high and busy is low, and its RGB word shows on
// rsp_word with rsp_strobe high for one cycle once it has left the back end.
// The result cannot be held off, so it must be captured in that cycle. A front
// stage clamps the hue (above 359 reads as 359), splits it into a 60-degree
// sector and remainder and flags grey pixels; a two-word queue feeds a
// five-stage back end that forms the three shade levels with constant
// reciprocal multiplies and routes them by sector. The back end drains the
// queue every cycle, so busy stays low and the sustained rate is one pixel per
// clock, set by the fully pipelined multiplier stages.
module hsv_to_rgb_converter import hsvrgb_pkg::*; #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   logic            push_valid;
   hsv_item_type    push_item;
   logic            pop_valid;
   hsv_item_type    pop_item;
   queue_level_type q_level;

   hsvrgb_front #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .level      (q_level),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   hsvrgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .level      (q_level)
   );

   hsvrgb_back #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pop_valid),
      .in_item    (pop_item),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   `HSVRGB_ASSERT_NOW(a_queue_bound, clock, reset, push_valid,
      q_level.count < QCW'(QUEUE_DEPTH) || q_level.popping, "queue overrun")
   `HSVRGB_ASSERT_LATER(a_latency, clock, reset, start && !busy, 7, rsp_strobe,
      "result word missing")
   `HSVRGB_ASSERT_LATER(a_grey, clock, reset, start && !busy && req_word.saturation == '0, 7,
      rsp_word.red == rsp_word.green && rsp_word.green == rsp_word.blue, "grey pixel not grey")

endmodule

### rtl/hsvrgb_front.sv
`timescale 1ns / 1ps

module hsvrgb_front import hsvrgb_pkg::*; #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_word_type    req_word,
   input  queue_level_type level,
   output logic            push_valid,
   output hsv_item_type    push_item
);

   localparam int EW = CHANNEL_BITS + FIELD_BITS;

   logic                valid_ff;
   logic                valid_in;
   hsv_item_type        item_ff;
   hsv_item_type        item_in;
   logic [EW-1:0]       sat_ext;
   logic [HUE_BITS-1:0] hue_clamped;
   logic [HUE_BITS-1:0] hue_rem;
   logic [QCW:0]        fill;
   logic                accept;

   // room needed for the word in the front register plus the one taken now
   assign fill = {1'b0, level.count} - (QCW + 1)'(level.popping) + (QCW + 1)'(valid_ff);
   assign busy = fill >= (QCW + 1)'(QUEUE_DEPTH);
   assign accept = start && !busy;

   assign sat_ext = EW'(req_word.saturation);
   assign hue_clamped = (req_word.hue > HUE_MAX) ? HUE_MAX : req_word.hue;

   always_comb begin
      item_in.grey = (sat_ext[CHANNEL_BITS-1:0] == '0);
      item_in.sector = hue_sector(hue_clamped);
      hue_rem = hue_clamped - sector_base(item_in.sector);
      item_in.rem = hue_rem[REM_BITS-1:0];
      item_in.sat = req_word.saturation;
      item_in.val = req_word.brightness;
   end

   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item = item_ff;

endmodule

### rtl/hsvrgb_queue.sv
`timescale 1ns / 1ps

module hsvrgb_queue import hsvrgb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  hsv_item_type    push_item,
   output logic            pop_valid,
   output hsv_item_type    pop_item,
   output queue_level_type level
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   hsv_item_type   mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff;
   logic [PW-1:0]  rd_ptr_in;
   logic [QCW-1:0] count_ff;
   logic [QCW-1:0] count_in;
   logic           pop;

   // the back end never stalls: drain whenever a word is held
   assign pop = (count_ff != '0);

   assign wr_ptr_in = !push_valid ? wr_ptr_ff :
                      (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in = count_ff + QCW'(push_valid) - QCW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_valid = pop;
   assign pop_item = mem_ff[rd_ptr_ff];
   assign level.count = count_ff;
   assign level.popping = pop;

endmodule

### rtl/hsvrgb_back.sv
`timescale 1ns / 1ps

module hsvrgb_back import hsvrgb_pkg::*; #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  hsv_item_type in_item,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int CB = CHANNEL_BITS;
   localparam int EW = CB + FIELD_BITS;
   localparam logic [63:0] CMAX = (64'd1 << CB) - 64'd1;
   localparam logic [63:0] DEN_Q = 64'd60 * CMAX;
   localparam int DW = $clog2(DEN_Q + 64'd1);
   localparam int NPW = 2 * CB;
   localparam int NQW = CB + DW;
   localparam int MPW = NPW - $clog2(CMAX + 64'd1) + 2;
   localparam int MQW = NQW - $clog2(DEN_Q + 64'd1) + 2;
   localparam logic [63:0] RECIP_P = (64'd1 << NPW) / CMAX;
   localparam logic [63:0] RECIP_Q = (64'd1 << NQW) / DEN_Q;
   localparam int PPW = NPW + MPW;
   localparam int PQW = NQW + MQW;

   // stage 1: shade factors
   logic [EW-1:0]  sat_ext;
   logic [EW-1:0]  val_ext;
   logic [CB-1:0]  s_c;
   logic [CB-1:0]  v_c;
   logic [DW-1:0]  s_r;
   logic [DW-1:0]  s_nr;
   logic           s1_valid_ff;
   logic           s1_grey_ff;
   sector_type     s1_sector_ff;
   logic [CB-1:0]  s1_v_ff;
   logic [CB-1:0]  s1_xp_ff;
   logic [CB-1:0]  s1_xp_in;
   logic [DW-1:0]  s1_xq_ff;
   logic [DW-1:0]  s1_xq_in;
   logic [DW-1:0]  s1_xt_ff;
   logic [DW-1:0]  s1_xt_in;

   // stage 2: numerators
   logic           s2_valid_ff;
   logic           s2_grey_ff;
   sector_type     s2_sector_ff;
   logic [CB-1:0]  s2_v_ff;
   logic [NPW-1:0] s2_np_ff;
   logic [NPW-1:0] s2_np_in;
   logic [NQW-1:0] s2_nq_ff;
   logic [NQW-1:0] s2_nq_in;
   logic [NQW-1:0] s2_nt_ff;
   logic [NQW-1:0] s2_nt_in;

   // stage 3: quotient estimates
   logic [PPW-1:0] prod_p;
   logic [PQW-1:0] prod_q;
   logic [PQW-1:0] prod_t;
   logic           s3_valid_ff;
   logic           s3_grey_ff;
   sector_type     s3_sector_ff;
   logic [CB-1:0]  s3_v_ff;
   logic [NPW-1:0] s3_np_ff;
   logic [NQW-1:0] s3_nq_ff;
   logic [NQW-1:0] s3_nt_ff;
   logic [CB-1:0]  s3_ep_ff;
   logic [CB-1:0]  s3_eq_ff;
   logic [CB-1:0]  s3_et_ff;

   // stage 4: corrected levels
   logic [NPW-1:0] rem_p;
   logic [NQW-1:0] rem_q;
   logic [NQW-1:0] rem_t;
   logic           s4_valid_ff;
   logic           s4_grey_ff;
   sector_type     s4_sector_ff;
   logic [CB-1:0]  s4_v_ff;
   logic [CB-1:0]  s4_p_ff;
   logic [CB-1:0]  s4_p_in;
   logic [CB-1:0]  s4_q_ff;
   logic [CB-1:0]  s4_q_in;
   logic [CB-1:0]  s4_t_ff;
   logic [CB-1:0]  s4_t_in;

   // stage 5: channel routing
   logic [CB-1:0]  r_c;
   logic [CB-1:0]  g_c;
   logic [CB-1:0]  b_c;
   logic [EW-1:0]  r_ext;
   logic [EW-1:0]  g_ext;
   logic [EW-1:0]  b_ext;
   logic           out_valid_ff;
   rsp_word_type   out_word_ff;
   rsp_word_type   out_word_in;

   assign sat_ext = EW'(in_item.sat);
   assign val_ext = EW'(in_item.val);
   assign s_c = sat_ext[CB-1:0];
   assign v_c = val_ext[CB-1:0];
   assign s_r = DW'(s_c) * DW'(in_item.rem);
   assign s_nr = DW'(s_c) * (DW'(SECTOR_DEG) - DW'(in_item.rem));
   assign s1_xp_in = CMAX[CB-1:0] - s_c;
   assign s1_xq_in = DEN_Q[DW-1:0] - s_r;
   assign s1_xt_in = DEN_Q[DW-1:0] - s_nr;

   assign s2_np_in = NPW'(s1_v_ff) * NPW'(s1_xp_ff);
   assign s2_nq_in = NQW'(s1_v_ff) * NQW'(s1_xq_ff);
   assign s2_nt_in = NQW'(s1_v_ff) * NQW'(s1_xt_ff);

   assign prod_p = PPW'(s2_np_ff) * PPW'(RECIP_P[MPW-1:0]);
   assign prod_q = PQW'(s2_nq_ff) * PQW'(RECIP_Q[MQW-1:0]);
   assign prod_t = PQW'(s2_nt_ff) * PQW'(RECIP_Q[MQW-1:0]);

   // estimate is low by at most one: fix with one compare
   assign rem_p = s3_np_ff - NPW'(s3_ep_ff) * CMAX[NPW-1:0];
   assign rem_q = s3_nq_ff - NQW'(s3_eq_ff) * DEN_Q[NQW-1:0];
   assign rem_t = s3_nt_ff - NQW'(s3_et_ff) * DEN_Q[NQW-1:0];
   assign s4_p_in = s3_ep_ff + CB'(rem_p >= CMAX[NPW-1:0]);
   assign s4_q_in = s3_eq_ff + CB'(rem_q >= DEN_Q[NQW-1:0]);
   assign s4_t_in = s3_et_ff + CB'(rem_t >= DEN_Q[NQW-1:0]);

   always_comb begin
      if (s4_grey_ff) begin
         r_c = s4_v_ff;
         g_c = s4_v_ff;
         b_c = s4_v_ff;
      end else begin
         unique case (s4_sector_ff)
            SECTOR_0: begin
               r_c = s4_v_ff; g_c = s4_t_ff; b_c = s4_p_ff;
            end
            SECTOR_1: begin
               r_c = s4_q_ff; g_c = s4_v_ff; b_c = s4_p_ff;
            end
            SECTOR_2: begin
               r_c = s4_p_ff; g_c = s4_v_ff; b_c = s4_t_ff;
            end
            SECTOR_3: begin
               r_c = s4_p_ff; g_c = s4_q_ff; b_c = s4_v_ff;
            end
            SECTOR_4: begin
               r_c = s4_t_ff; g_c = s4_p_ff; b_c = s4_v_ff;
            end
            default: begin
               r_c = s4_v_ff; g_c = s4_p_ff; b_c = s4_q_ff;
            end
         endcase
      end
   end

   assign r_ext = EW'(r_c);
   assign g_ext = EW'(g_c);
   assign b_ext = EW'(b_c);
   assign out_word_in.red = r_ext[FIELD_BITS-1:0];
   assign out_word_in.green = g_ext[FIELD_BITS-1:0];
   assign out_word_in.blue = b_ext[FIELD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_grey_ff <= in_item.grey;
      s1_sector_ff <= in_item.sector;
      s1_v_ff <= v_c;
      s1_xp_ff <= s1_xp_in;
      s1_xq_ff <= s1_xq_in;
      s1_xt_ff <= s1_xt_in;

      s2_grey_ff <= s1_grey_ff;
      s2_sector_ff <= s1_sector_ff;
      s2_v_ff <= s1_v_ff;
      s2_np_ff <= s2_np_in;
      s2_nq_ff <= s2_nq_in;
      s2_nt_ff <= s2_nt_in;

      s3_grey_ff <= s2_grey_ff;
      s3_sector_ff <= s2_sector_ff;
      s3_v_ff <= s2_v_ff;
      s3_np_ff <= s2_np_ff;
      s3_nq_ff <= s2_nq_ff;
      s3_nt_ff <= s2_nt_ff;
      s3_ep_ff <= prod_p[NPW +: CB];
      s3_eq_ff <= prod_q[NQW +: CB];
      s3_et_ff <= prod_t[NQW +: CB];

      s4_grey_ff <= s3_grey_ff;
      s4_sector_ff <= s3_sector_ff;
      s4_v_ff <= s3_v_ff;
      s4_p_ff <= s4_p_in;
      s4_q_ff <= s4_q_in;
      s4_t_ff <= s4_t_in;

      out_word_ff <= out_word_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_word = out_word_ff;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import hsvrgb_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT = 200000;
   localparam int CHANNEL_MAX = (1 << FIELD_BITS) - 1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   rsp_word_type pending_rgb[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           sender_idle_pct = 0;

   hsv_to_rgb_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic rsp_word_type rgb_from_hsv(input req_word_type px);
      int unsigned  h;
      int unsigned  s;
      int unsigned  v;
      int unsigned  rem;
      int unsigned  span;
      int unsigned  p;
      int unsigned  q;
      int unsigned  t;
      int unsigned  ch_r;
      int unsigned  ch_g;
      int unsigned  ch_b;
      sector_type   sec;
      rsp_word_type rgb;
      h = px.hue;
      if (h > HUE_MAX) h = HUE_MAX;
      s = px.saturation;
      v = px.brightness;
      span = SECTOR_DEG * CHANNEL_MAX;
      if (s == 0) begin
         ch_r = v;
         ch_g = v;
         ch_b = v;
      end else begin
         sec = sector_type'(h / SECTOR_DEG);
         rem = h % SECTOR_DEG;
         p = (v * (CHANNEL_MAX - s)) / CHANNEL_MAX;
         q = (v * (span - s * rem)) / span;
         t = (v * (span - s * (SECTOR_DEG - rem))) / span;
         case (sec)
            SECTOR_0: begin ch_r = v; ch_g = t; ch_b = p; end
            SECTOR_1: begin ch_r = q; ch_g = v; ch_b = p; end
            SECTOR_2: begin ch_r = p; ch_g = v; ch_b = t; end
            SECTOR_3: begin ch_r = p; ch_g = q; ch_b = v; end
            SECTOR_4: begin ch_r = t; ch_g = p; ch_b = v; end
            default:  begin ch_r = v; ch_g = p; ch_b = q; end
         endcase
      end
      rgb.red = ch_r[FIELD_BITS-1:0];
      rgb.green = ch_g[FIELD_BITS-1:0];
      rgb.blue = ch_b[FIELD_BITS-1:0];
      return rgb;
   endfunction

   function automatic req_word_type make_pixel(input int hue, input int sat, input int val);
      req_word_type px;
      px.hue = hue[HUE_BITS-1:0];
      px.saturation = sat[FIELD_BITS-1:0];
      px.brightness = val[FIELD_BITS-1:0];
      return px;
   endfunction

   function automatic int random_channel();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return 0;
      if (pick == 1) return CHANNEL_MAX;
      return $urandom_range(CHANNEL_MAX);
   endfunction

   function automatic req_word_type random_pixel();
      int pick;
      int hue;
      pick = $urandom_range(9);
      if (pick == 0)
         hue = $urandom_range((1 << HUE_BITS) - 1, HUE_MAX + 1);
      else if (pick == 1)
         hue = $urandom_range(5) * SECTOR_DEG + ($urandom_range(1) ? SECTOR_DEG - 1 : 0);
      else
         hue = $urandom_range(HUE_MAX);
      return make_pixel(hue, random_channel(), random_channel());
   endfunction

   // hold start low while a random draw falls below the idle percentage, then present the word
   task automatic send_pixel(input req_word_type px);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rgb.push_back(rgb_from_hsv(px));
   endtask

   task automatic report_channel(input string name, input logic [FIELD_BITS-1:0] exp_v,
                                 input logic [FIELD_BITS-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type exp_rgb;
      if (!reset && rsp_strobe) begin
         if (pending_rgb.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_word);
            mismatch_count++;
         end else begin
            exp_rgb = pending_rgb.pop_front();
            report_channel("red", exp_rgb.red, rsp_word.red);
            report_channel("green", exp_rgb.green, rsp_word.green);
            report_channel("blue", exp_rgb.blue, rsp_word.blue);
         end
      end
   end

   task automatic test_sector_edges();
      for (int sec = 0; sec < 6; sec++) begin
         send_pixel(make_pixel(sec * SECTOR_DEG, CHANNEL_MAX, CHANNEL_MAX));
         send_pixel(make_pixel(sec * SECTOR_DEG + SECTOR_DEG - 1, CHANNEL_MAX, CHANNEL_MAX));
      end
      send_pixel(make_pixel(30, 128, 128));
   endtask

   task automatic test_hue_clamp();
      send_pixel(make_pixel(HUE_MAX + 1, 200, 180));
      send_pixel(make_pixel((1 << HUE_BITS) - 1, CHANNEL_MAX, CHANNEL_MAX));
      send_pixel(make_pixel(400, 1, 255));
   endtask

   task automatic test_grey_and_extremes();
      send_pixel(make_pixel(100, 0, 200));
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel((1 << HUE_BITS) - 1, 0, CHANNEL_MAX));
      send_pixel(make_pixel(200, CHANNEL_MAX, 0));
      send_pixel(make_pixel(250, 1, CHANNEL_MAX));
      send_pixel(make_pixel(330, CHANNEL_MAX, 1));
   endtask

   task automatic test_random_pixels(input int count, input int idle_pct);
      sender_idle_pct = idle_pct;
      repeat (count) send_pixel(random_pixel());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 20;
      test_sector_edges();
      test_hue_clamp();
      test_grey_and_extremes();
      test_random_pixels(420, 20);
      test_random_pixels(420, 70);
      test_random_pixels(410, 0);
      start <= 1'b0;
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
